@@ hdl/mge_pkg.sv @@
// Shared constants and types for the multitone grid enumerator.
// No dependencies; every other file imports this package.
`default_nettype none

package mge_pkg;

	localparam int NUM_TONES  = 4;
	localparam int MAX_HARM   = 15;
	localparam int WEIGHT_W   = 5;
	localparam int HARM_W     = 4;
	localparam int ORDER_W    = 6;
	localparam int COUNT_W    = 3;
	localparam int TONE_IDX_W = $clog2(NUM_TONES);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic [HARM_W-1:0]          harm_t;
	typedef logic [ORDER_W-1:0]         order_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE_COUNT   = 3'd0,
		REG_HARM_FIRST   = 3'd1,
		REG_HARM_SECOND  = 3'd2,
		REG_HARM_THIRD   = 3'd3,
		REG_HARM_FOURTH  = 3'd4,
		REG_MAX_IM_ORDER = 3'd5,
		REG_HYBRID_MODE  = 3'd6
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ hdl/mge_if.sv @@
// Handshake channels of the grid enumerator: request word in, grid point word out.
// Depends on mge_pkg.
`default_nettype none

interface mge_req_if;
	import mge_pkg::*;

	logic valid;
	logic ready;
	logic restart;

	modport source  (output valid, output restart, input ready);
	modport sink    (input valid, input restart, output ready);
	modport monitor (input valid, input restart, input ready);
endinterface

interface mge_res_if;
	import mge_pkg::*;

	logic    valid;
	logic    ready;
	weight_t weight_first;
	weight_t weight_second;
	weight_t weight_third;
	weight_t weight_fourth;
	order_t  mix_order;
	count_t  nonzero_count;
	logic    is_harmonic;
	logic    kept;
	logic    last;
	logic    exhausted;

	modport source (
		output valid, input ready,
		output weight_first, output weight_second, output weight_third, output weight_fourth,
		output mix_order, output nonzero_count, output is_harmonic, output kept,
		output last, output exhausted
	);
	modport sink (
		input valid, output ready,
		input weight_first, input weight_second, input weight_third, input weight_fourth,
		input mix_order, input nonzero_count, input is_harmonic, input kept,
		input last, input exhausted
	);
	modport monitor (
		input valid, input ready,
		input weight_first, input weight_second, input weight_third, input weight_fourth,
		input mix_order, input nonzero_count, input is_harmonic, input kept,
		input last, input exhausted
	);
endinterface

`default_nettype wire

@@ hdl/multitone_grid_enumerator.sv @@
// Multitone harmonic grid enumerator: top level, counter, point metrics and result register.
// Depends on mge_pkg and the channel interfaces in mge_if.sv.
`default_nettype none

// Each request word returns exactly one grid point word, in the cycle after it is taken,
// and a request can be taken every cycle: the weight counter, the order sum and the
// carry search are all combinational and the result register sits on the output, so
// the input only stalls while that register holds a word the sink has not yet taken.
// A request with restart set rewinds to the all-zero point; after the point flagged
// last, further requests without restart return words flagged exhausted.
// Configuration writes are only to be made while no word is in flight.
module multitone_grid_enumerator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire mge_pkg::cfg_idx_t  wr_index,
	input  wire mge_pkg::cfg_data_t wr_data,
	mge_req_if.sink                request,
	mge_res_if.source              result
);
	import mge_pkg::*;

	// configuration
	logic [COUNT_W-1:0] tone_count_q;
	harm_t              harm_q [NUM_TONES];
	order_t             max_im_order_q;
	logic               hybrid_mode_q;

	// counter state
	weight_t w_q [NUM_TONES];
	logic    fin_q;

	// result register
	logic    res_valid_q;
	weight_t res_w_q [NUM_TONES];
	order_t  res_order_q;
	count_t  res_nnz_q;
	logic    res_harm_q;
	logic    res_kept_q;
	logic    res_last_q;
	logic    res_exh_q;

	logic                  accept;
	logic                  fin_eff;
	logic [NUM_TONES-1:0]  in_use;
	weight_t               wz [NUM_TONES];
	logic [NUM_TONES-1:0]  can_inc;
	logic [NUM_TONES:0]    pre_zero;
	logic                  found;
	logic [TONE_IDX_W-1:0] chg;
	logic                  all_zero;
	weight_t               w_next [NUM_TONES];
	logic [WEIGHT_W-1:0]   mag [NUM_TONES];
	order_t                order;
	count_t                nnz;
	harm_t                 hmax;
	order_t                immax;
	logic                  keep;

	assign request.ready = !res_valid_q || result.ready;
	assign accept        = request.valid && request.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_count_q   <= COUNT_W'(1);
			max_im_order_q <= '0;
			hybrid_mode_q  <= 1'b0;
			for (int i = 0; i < NUM_TONES; i++) begin
				harm_q[i] <= HARM_W'(1);
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_TONE_COUNT:   tone_count_q   <= wr_data[COUNT_W-1:0];
				REG_HARM_FIRST:   harm_q[0]      <= wr_data[HARM_W-1:0];
				REG_HARM_SECOND:  harm_q[1]      <= wr_data[HARM_W-1:0];
				REG_HARM_THIRD:   harm_q[2]      <= wr_data[HARM_W-1:0];
				REG_HARM_FOURTH:  harm_q[3]      <= wr_data[HARM_W-1:0];
				REG_MAX_IM_ORDER: max_im_order_q <= wr_data[ORDER_W-1:0];
				REG_HYBRID_MODE:  hybrid_mode_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Current point as seen by this word: restart rewinds, unused tones read zero.
	always_comb begin
		fin_eff = request.restart ? 1'b0 : fin_q;
		for (int i = 0; i < NUM_TONES; i++) begin
			// tone count of zero acts as one, larger values clip at NUM_TONES
			in_use[i] = (i == 0) || (COUNT_W'(i) < tone_count_q);
			wz[i]     = (in_use[i] && !request.restart) ? w_q[i] : '0;
			can_inc[i] = in_use[i] &&
				($signed({wz[i][WEIGHT_W-1], wz[i]}) < $signed({2'b00, harm_q[i]}));
		end
	end

	// Carry search: the last tone counts fastest, so take the highest tone that can step.
	always_comb begin
		found = 1'b0;
		chg   = '0;
		for (int i = 0; i < NUM_TONES; i++) begin
			if (can_inc[i]) begin
				found = 1'b1;
				chg   = TONE_IDX_W'(i);
			end
		end
		pre_zero[0] = 1'b1;
		for (int i = 0; i < NUM_TONES; i++) begin
			pre_zero[i+1] = pre_zero[i] && (wz[i] == '0);
		end
		// after the step the stepped weight is zero only if it was minus one
		all_zero = pre_zero[chg] && (wz[chg] == -WEIGHT_W'(1));
		for (int i = 0; i < NUM_TONES; i++) begin
			if (!found || TONE_IDX_W'(i) < chg) begin
				w_next[i] = wz[i];
			end else if (TONE_IDX_W'(i) == chg) begin
				w_next[i] = wz[i] + WEIGHT_W'(1);
			end else if (in_use[i] && !all_zero) begin
				w_next[i] = WEIGHT_W'(-$signed({1'b0, harm_q[i]}));
			end else begin
				w_next[i] = '0;
			end
		end
	end

	// Point metrics and truncation test.
	always_comb begin
		order = '0;
		nnz   = '0;
		hmax  = '0;
		for (int i = 0; i < NUM_TONES; i++) begin
			mag[i] = wz[i][WEIGHT_W-1] ? WEIGHT_W'(-wz[i]) : WEIGHT_W'(wz[i]);
			order  = order + ORDER_W'(mag[i]);
			if (wz[i] != '0) begin
				nnz = nnz + COUNT_W'(1);
			end
			if (in_use[i] && harm_q[i] > hmax) begin
				hmax = harm_q[i];
			end
		end
		immax = (max_im_order_q > ORDER_W'(hmax)) ? max_im_order_q : ORDER_W'(hmax);
		keep  = (max_im_order_q == '0) || (order <= immax) ||
			(hybrid_mode_q && nnz <= COUNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b1;
			for (int i = 0; i < NUM_TONES; i++) begin
				w_q[i] <= '0;
			end
		end else if (accept) begin
			if (fin_eff || !found) begin
				fin_q <= 1'b1;
				for (int i = 0; i < NUM_TONES; i++) begin
					w_q[i] <= wz[i];
				end
			end else begin
				fin_q <= 1'b0;
				for (int i = 0; i < NUM_TONES; i++) begin
					w_q[i] <= w_next[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (fin_eff) begin
				for (int i = 0; i < NUM_TONES; i++) begin
					res_w_q[i] <= '0;
				end
				res_order_q <= '0;
				res_nnz_q   <= '0;
				res_harm_q  <= 1'b0;
				res_kept_q  <= 1'b0;
				res_last_q  <= 1'b0;
				res_exh_q   <= 1'b1;
			end else begin
				for (int i = 0; i < NUM_TONES; i++) begin
					res_w_q[i] <= wz[i];
				end
				res_order_q <= order;
				res_nnz_q   <= nnz;
				res_harm_q  <= (nnz <= COUNT_W'(1));
				res_kept_q  <= keep;
				res_last_q  <= !found;
				res_exh_q   <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.weight_first  = res_w_q[0];
	assign result.weight_second = res_w_q[1];
	assign result.weight_third  = res_w_q[2];
	assign result.weight_fourth = res_w_q[3];
	assign result.mix_order     = res_order_q;
	assign result.nonzero_count = res_nnz_q;
	assign result.is_harmonic   = res_harm_q;
	assign result.kept          = res_kept_q;
	assign result.last          = res_last_q;
	assign result.exhausted     = res_exh_q;

endmodule

`default_nettype wire

@@ hdl/mge_checker.sv @@
// Port-level checks for the multitone grid enumerator, bound to the top level.
// Depends on mge_pkg and the channel interfaces in mge_if.sv.
`default_nettype none

module mge_checker (
	input wire logic  clk,
	input wire logic  arst_n,
	mge_req_if.sink   request,
	mge_res_if.source result
);
	import mge_pkg::*;

	// an exhausted word carries nothing else
	a_exhausted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.exhausted) |->
			(result.weight_first == '0 && result.weight_second == '0 &&
			 result.weight_third == '0 && result.weight_fourth == '0 &&
			 result.mix_order == '0 && result.nonzero_count == '0 &&
			 !result.kept && !result.last))
		else $error("exhausted word with live fields");

	// a restart word comes back next cycle as the all-zero first point
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready && request.restart) |=>
			(result.valid && !result.exhausted &&
			 result.weight_first == '0 && result.weight_second == '0 &&
			 result.weight_third == '0 && result.weight_fourth == '0 &&
			 result.mix_order == '0 && result.kept))
		else $error("restart did not yield the first point");

	// live point: first weight never negative, order covers every nonzero weight
	a_point_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.exhausted) |->
			(!result.weight_first[WEIGHT_W-1] &&
			 ORDER_W'(result.nonzero_count) <= result.mix_order &&
			 result.is_harmonic == (result.nonzero_count <= COUNT_W'(1))))
		else $error("inconsistent grid point");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=>
			(result.valid && $stable(result.weight_first) && $stable(result.mix_order) &&
			 $stable(result.last) && $stable(result.exhausted)))
		else $error("result word changed while stalled");

endmodule

bind multitone_grid_enumerator mge_checker u_mge_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.request (request),
	.result  (result)
);

`default_nettype wire
